### hdl/cnp_pkg.sv
// Shared types and constants for the coverage navigation policy core.
// No dependencies; imported by cnp_decide and the top level.
`default_nettype none

package cnp_pkg;

    // maneuver codes
    localparam logic [2:0] MV_NONE        = 3'd0;
    localparam logic [2:0] MV_FORWARD     = 3'd1;
    localparam logic [2:0] MV_QUARTER_CW  = 3'd2;
    localparam logic [2:0] MV_QUARTER_CCW = 3'd3;
    localparam logic [2:0] MV_UTURN_CW    = 3'd4;
    localparam logic [2:0] MV_UTURN_CCW   = 3'd5;
    localparam logic [2:0] MV_STUCK       = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_FRONT_LIMIT = 2'd0;
    localparam logic [1:0] REG_SIDE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PERIOD      = 2'd2;

    localparam logic [15:0] FRONT_LIMIT_RESET = 16'd464;  // 8 cm * 58
    localparam logic [15:0] SIDE_LIMIT_RESET  = 16'd290;  // 5 cm * 58
    localparam logic [7:0]  PERIOD_RESET      = 8'd50;
    localparam logic [15:0] CLEAR_ECHO_US     = 16'd5800; // 100 cm * 58
    localparam logic [7:0]  COUNT_MAX         = 8'd255;

    typedef struct packed {
        logic       first_sample;
        logic       stuck;
        logic       forced_turn;
        logic       prefer_cw;
        logic [7:0] uturn_count;
    } nav_state_t;

    typedef struct packed {
        logic       backed_up;
        logic [2:0] maneuver;
        logic       prefers_clockwise;
        logic [7:0] uturns_done;
    } nav_result_t;

endpackage

`default_nettype wire

### hdl/cnp_mod_unit.sv
// Iterative 8-bit remainder unit (restoring, one bit per cycle).
// Depends on nothing but its ports; used by the top level after a period write.
`default_nettype none

module cnp_mod_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] dividend,
    input  wire logic [7:0] divisor,
    output logic            busy,
    output logic            done,
    output logic [7:0]      remainder
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] rem_reg, rem_next;
    logic [8:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[7]};
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = 3'd0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = 8'd0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
                rem_next = 8'(shifted - {1'b0, div_reg});
            else
                rem_next = shifted[7:0];
            dvd_next = {dvd_reg[6:0], 1'b0};
            bit_next = 3'(bit_reg + 3'd1);
            if (bit_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hdl/cnp_decide.sv
// Combinational maneuver decision for one echo sample.
// Depends on cnp_pkg for state/result structs and maneuver codes.
`default_nettype none

module cnp_decide (
    input  wire cnp_pkg::nav_state_t state,
    input  wire logic [15:0]     front_limit,
    input  wire logic [15:0]     side_limit,
    input  wire logic            quarter_due,
    input  wire logic [15:0]     front_echo,
    input  wire logic [15:0]     left_echo,
    input  wire logic [15:0]     right_echo,
    output cnp_pkg::nav_state_t  state_next,
    output cnp_pkg::nav_result_t result,
    output logic                 count_step
);
    import cnp_pkg::*;

    logic [15:0] f, l, r;
    logic        stuck_mid, forced_mid;
    logic        right_blocked, left_blocked;
    logic        dir_cw, flip;
    logic        backed;
    logic [2:0]  mv;

    always_comb
    begin
        state_next = state;
        state_next.first_sample = 1'b0;
        count_step = 1'b0;
        backed     = 1'b0;
        mv         = MV_NONE;

        if (state.first_sample)
        begin
            f = CLEAR_ECHO_US;
            l = CLEAR_ECHO_US;
            r = CLEAR_ECHO_US;
        end
        else
        begin
            f = front_echo;
            l = left_echo;
            r = right_echo;
        end

        right_blocked = r < side_limit;
        left_blocked  = l < side_limit;
        dir_cw = state.prefer_cw ? !right_blocked : left_blocked;
        flip   = state.prefer_cw ? !right_blocked : !left_blocked;

        stuck_mid  = state.stuck;
        forced_mid = state.forced_turn;
        if (state.stuck)
        begin
            backed = 1'b1;
            if (r > side_limit || l > side_limit)
            begin
                forced_mid = 1'b1;
                stuck_mid  = 1'b0;
            end
        end
        state_next.stuck       = stuck_mid;
        state_next.forced_turn = forced_mid;

        if (!stuck_mid && (f < front_limit || forced_mid))
        begin
            state_next.forced_turn = 1'b0;
            if (right_blocked && left_blocked)
            begin
                state_next.stuck = 1'b1;
                mv = MV_STUCK;
            end
            else if (quarter_due)
            begin
                mv = dir_cw ? MV_QUARTER_CW : MV_QUARTER_CCW;
            end
            else
            begin
                mv = dir_cw ? MV_UTURN_CW : MV_UTURN_CCW;
                if (state.uturn_count != COUNT_MAX)
                begin
                    count_step = 1'b1;
                    state_next.uturn_count = 8'(state.uturn_count + 8'd1);
                end
                if (flip)
                    state_next.prefer_cw = !state.prefer_cw;
            end
        end
        else if (!stuck_mid)
        begin
            mv = MV_FORWARD;
        end

        result.backed_up         = backed;
        result.maneuver          = mv;
        result.prefers_clockwise = state_next.prefer_cw;
        result.uturns_done       = state_next.uturn_count;
    end

endmodule

`default_nettype wire

### hdl/coverage_navigation_policy_core.sv
// Coverage navigation policy core: top level with input, state and result registers.
// Depends on cnp_pkg, cnp_decide and cnp_mod_unit.
// Samples go through the s1 and result registers; one item per cycle unless stalled.
// A period write recomputes count mod period in cnp_mod_unit; input is held off meanwhile.
// Reset: asynchronous active low; limits to 464/290/50, first sample treated as clear,
// prefer clockwise, U-turn count 0, both channels empty.
`default_nettype none

module coverage_navigation_policy_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] front_echo_us,
    input  wire logic [15:0] left_echo_us,
    input  wire logic [15:0] right_echo_us,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             backed_up,
    output logic [2:0]       maneuver,
    output logic             prefers_clockwise,
    output logic [7:0]       uturns_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import cnp_pkg::*;

    logic [15:0] front_limit_reg;
    logic [15:0] side_limit_reg;
    logic [7:0]  period_reg;
    logic [7:0]  phase_reg;   // uturn_count mod period, kept incrementally

    nav_state_t  state_reg, state_next;
    nav_result_t result_next, result_reg;
    logic        count_step;

    logic        s1_valid_reg;
    logic [15:0] s1_front_reg, s1_left_reg, s1_right_reg;
    logic        out_valid_reg;

    logic        mod_busy, mod_done, mod_start;
    logic [7:0]  mod_rem;
    logic        s1_fire, in_fire, cfg_fire;
    logic        quarter_due;
    logic [7:0]  phase_inc;

    assign cfg_ready = !mod_busy;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign mod_start = cfg_fire && cfg_index == REG_PERIOD;

    assign s1_fire  = s1_valid_reg && !mod_busy && !mod_done
                      && (!out_valid_reg || out_ready);
    assign in_ready = !mod_busy && (!s1_valid_reg || s1_fire);
    assign in_fire  = in_valid && in_ready;

    assign quarter_due = period_reg != 8'd0 && state_reg.uturn_count != 8'd0
                         && phase_reg == 8'd0;
    assign phase_inc   = 8'(phase_reg + 8'd1);

    cnp_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (state_reg.uturn_count),
        .divisor   (cfg_data[7:0]),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cnp_decide u_decide (
        .state       (state_reg),
        .front_limit (front_limit_reg),
        .side_limit  (side_limit_reg),
        .quarter_due (quarter_due),
        .front_echo  (s1_front_reg),
        .left_echo   (s1_left_reg),
        .right_echo  (s1_right_reg),
        .state_next  (state_next),
        .result      (result_next),
        .count_step  (count_step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_limit_reg <= FRONT_LIMIT_RESET;
            side_limit_reg  <= SIDE_LIMIT_RESET;
            period_reg      <= PERIOD_RESET;
            phase_reg       <= 8'd0;
            state_reg       <= '{first_sample: 1'b1, stuck: 1'b0, forced_turn: 1'b0,
                                 prefer_cw: 1'b1, uturn_count: 8'd0};
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_FRONT_LIMIT: front_limit_reg <= cfg_data;
                    REG_SIDE_LIMIT:  side_limit_reg  <= cfg_data;
                    REG_PERIOD:      period_reg      <= cfg_data[7:0];
                    default:         ;
                endcase
            end

            if (mod_done)
                phase_reg <= mod_rem;
            else if (s1_fire && count_step)
                phase_reg <= ({1'b0, phase_inc} == {1'b0, period_reg}) ? 8'd0 : phase_inc;

            if (s1_fire)
                state_reg <= state_next;

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_front_reg <= front_echo_us;
            s1_left_reg  <= left_echo_us;
            s1_right_reg <= right_echo_us;
        end
        if (s1_fire)
            result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign backed_up         = result_reg.backed_up;
    assign maneuver          = result_reg.maneuver;
    assign prefers_clockwise = result_reg.prefers_clockwise;
    assign uturns_done       = result_reg.uturns_done;

endmodule

`default_nettype wire
